>>> rtl/crab_pkg.sv
// Shared constants and register indexes for the clipped RGBA alpha blitter.
// No dependencies; imported by crab_blend and clipped_rgba_alpha_blit.
package crab_pkg;

   // Largest canvas or sprite dimension in pixels.
   localparam int MAX_DIM  = 1024;

   // Fixed field widths.
   localparam int CHAN_W   = 8;
   localparam int CFG_W    = 11;
   localparam int ADDR_W   = 20;

   // Widths that follow from MAX_DIM.
   localparam int CNT_W    = $clog2(MAX_DIM);
   localparam int DIM_W    = CNT_W + 1;
   localparam int CLAMP_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
   localparam int COORD_W  = ((CFG_W > CNT_W) ? CFG_W : CNT_W) + 2;
   localparam int PROD_W   = CNT_W + CLAMP_W + 1;

   localparam logic [CHAN_W-1:0] CHAN_MAX   = '1;
   localparam logic [CHAN_W-1:0] CHAN_ROUND = CHAN_MAX >> 1;

   // Register indexes on the configuration port; REG_UNMAPPED is the first
   // index past the register list.
   typedef enum logic [2:0] {
      REG_CANVAS_WIDTH  = 3'd0,
      REG_CANVAS_HEIGHT = 3'd1,
      REG_DEST_X        = 3'd2,
      REG_DEST_Y        = 3'd3,
      REG_SRC_WIDTH     = 3'd4,
      REG_SRC_HEIGHT    = 3'd5,
      REG_UNMAPPED      = 3'd6
   } reg_index_type;

endpackage

>>> rtl/crab_blend.sv
// One color channel of the source-over blend: (s*a + d*(255-a) + 127) / 255.
// Depends on crab_pkg for the channel width and blend constants.
module crab_blend (
   input  logic [crab_pkg::CHAN_W-1:0] src,
   input  logic [crab_pkg::CHAN_W-1:0] dst,
   input  logic [crab_pkg::CHAN_W-1:0] alpha,
   output logic [crab_pkg::CHAN_W-1:0] result
);
   import crab_pkg::*;

   localparam int SUM_W = 2 * CHAN_W + 1;

   logic [2*CHAN_W-1:0] prod_src;
   logic [2*CHAN_W-1:0] prod_dst;
   logic [SUM_W-1:0]    sum;
   logic [SUM_W-1:0]    quot;

   assign prod_src = (2*CHAN_W)'(src) * (2*CHAN_W)'(alpha);
   assign prod_dst = (2*CHAN_W)'(dst) * (2*CHAN_W)'(CHAN_MAX - alpha);
   assign sum      = SUM_W'(prod_src) + SUM_W'(prod_dst) + SUM_W'(CHAN_ROUND);

   // Divide by 255 with the reciprocal trick, exact for sums below 2^16 - 1.
   assign quot     = (sum + (sum >> CHAN_W) + SUM_W'(1)) >> CHAN_W;
   assign result   = quot[CHAN_W-1:0];

endmodule

>>> rtl/clipped_rgba_alpha_blit.sv
// Top level of the clipped RGBA alpha blitter: raster counters, clipping,
// blend and address, APB-style register port. Depends on crab_pkg, crab_blend.
//
//   channel   direction  handshake         carries
//   req_*     in         valid / ready     sprite RGBA pixel and canvas RGB under it
//   rsp_*     out        valid / ready     write enable, canvas address, blended RGB, last
//   csr_*     in         psel / penable    six configuration registers, 4-byte stride
//
// One transaction per clock sustained while rsp_ready is high; rsp_valid rises once the
// input register and then the result register (holding blend and address) have taken it.
// The result register carries the 8x8 blend multiplies and the row-times-width
// multiply; the input stage holds the counter, clip compare and last flag.
// Reset clears the counters and valid flags and restores register defaults.
// A stalled rsp_ready holds both stages; req_ready drops only when both are full.
module clipped_rgba_alpha_blit (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [crab_pkg::CHAN_W-1:0] req_src_red,
   input  logic [crab_pkg::CHAN_W-1:0] req_src_green,
   input  logic [crab_pkg::CHAN_W-1:0] req_src_blue,
   input  logic [crab_pkg::CHAN_W-1:0] req_src_alpha,
   input  logic [crab_pkg::CHAN_W-1:0] req_canvas_red,
   input  logic [crab_pkg::CHAN_W-1:0] req_canvas_green,
   input  logic [crab_pkg::CHAN_W-1:0] req_canvas_blue,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_write_enable,
   output logic [crab_pkg::ADDR_W-1:0] rsp_pixel_address,
   output logic [crab_pkg::CHAN_W-1:0] rsp_out_red,
   output logic [crab_pkg::CHAN_W-1:0] rsp_out_green,
   output logic [crab_pkg::CHAN_W-1:0] rsp_out_blue,
   output logic                        rsp_last_pixel,

   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [4:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import crab_pkg::*;

   // Input-stage payload: pixel data plus clip results for this pixel.
   typedef struct packed {
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
      logic [CHAN_W-1:0] canvas_red;
      logic [CHAN_W-1:0] canvas_green;
      logic [CHAN_W-1:0] canvas_blue;
      logic [CNT_W-1:0]  x;
      logic [CNT_W-1:0]  y;
      logic              in_canvas;
      logic              last;
   } stage_type;

   // ---------------------------------------------------------------- registers
   logic [CFG_W-1:0] canvas_width_ff, canvas_height_ff;
   logic [CFG_W-1:0] dest_x_ff, dest_y_ff;
   logic [CFG_W-1:0] src_width_ff, src_height_ff;

   reg_index_type    csr_index;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= CFG_W'(MAX_DIM);
         canvas_height_ff <= CFG_W'(MAX_DIM);
         dest_x_ff        <= '0;
         dest_y_ff        <= '0;
         src_width_ff     <= CFG_W'(1);
         src_height_ff    <= CFG_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CANVAS_WIDTH:  canvas_width_ff  <= csr_pwdata[CFG_W-1:0];
            REG_CANVAS_HEIGHT: canvas_height_ff <= csr_pwdata[CFG_W-1:0];
            REG_DEST_X:        dest_x_ff        <= csr_pwdata[CFG_W-1:0];
            REG_DEST_Y:        dest_y_ff        <= csr_pwdata[CFG_W-1:0];
            REG_SRC_WIDTH:     src_width_ff     <= csr_pwdata[CFG_W-1:0];
            REG_SRC_HEIGHT:    src_height_ff    <= csr_pwdata[CFG_W-1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CANVAS_WIDTH:  csr_prdata = 32'(canvas_width_ff);
         REG_CANVAS_HEIGHT: csr_prdata = 32'(canvas_height_ff);
         REG_DEST_X:        csr_prdata = 32'(dest_x_ff);
         REG_DEST_Y:        csr_prdata = 32'(dest_y_ff);
         REG_SRC_WIDTH:     csr_prdata = 32'(src_width_ff);
         REG_SRC_HEIGHT:    csr_prdata = 32'(src_height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------- clamped dimensions
   logic [CLAMP_W-1:0] src_w, src_h, canvas_w, canvas_h;

   // Sprite sizes: zero acts as one, anything above MAX_DIM saturates.
   // Canvas sizes only saturate; zero clips everything away.
   always_comb begin
      src_w    = CLAMP_W'(src_width_ff);
      src_h    = CLAMP_W'(src_height_ff);
      canvas_w = CLAMP_W'(canvas_width_ff);
      canvas_h = CLAMP_W'(canvas_height_ff);
      if (src_w == '0)                   src_w    = CLAMP_W'(1);
      if (src_w > CLAMP_W'(MAX_DIM))     src_w    = CLAMP_W'(MAX_DIM);
      if (src_h == '0)                   src_h    = CLAMP_W'(1);
      if (src_h > CLAMP_W'(MAX_DIM))     src_h    = CLAMP_W'(MAX_DIM);
      if (canvas_w > CLAMP_W'(MAX_DIM))  canvas_w = CLAMP_W'(MAX_DIM);
      if (canvas_h > CLAMP_W'(MAX_DIM))  canvas_h = CLAMP_W'(MAX_DIM);
   end

   // ------------------------------------------------------------ handshakes
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_load;
   logic      s1_load;

   // The result register takes a new value whenever it is empty or being drained.
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_load;
   assign s1_load   = req_valid && req_ready;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !out_load);
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !out_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // -------------------------------------------------------- raster counters
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic               end_col, end_row, last;
   logic [COORD_W-1:0] x_pos, y_pos;
   logic               in_canvas;

   // A counter at or past the last column or row ends it, so a size shrunk
   // mid-blit still terminates.
   assign end_col = CLAMP_W'(col_ff) >= (src_w - CLAMP_W'(1));
   assign end_row = CLAMP_W'(row_ff) >= (src_h - CLAMP_W'(1));
   assign last    = end_col && end_row;

   assign x_pos     = COORD_W'(signed'(dest_x_ff)) + COORD_W'(col_ff);
   assign y_pos     = COORD_W'(signed'(dest_y_ff)) + COORD_W'(row_ff);
   assign in_canvas = !x_pos[COORD_W-1] && !y_pos[COORD_W-1]
                      && (x_pos < COORD_W'(canvas_w)) && (y_pos < COORD_W'(canvas_h));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (s1_load) begin
         priority if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (end_col) begin
            col_in = '0;
            row_in = row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------ input stage
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff.src_red      <= req_src_red;
         s1_ff.src_green    <= req_src_green;
         s1_ff.src_blue     <= req_src_blue;
         s1_ff.src_alpha    <= req_src_alpha;
         s1_ff.canvas_red   <= req_canvas_red;
         s1_ff.canvas_green <= req_canvas_green;
         s1_ff.canvas_blue  <= req_canvas_blue;
         s1_ff.x            <= x_pos[CNT_W-1:0];
         s1_ff.y            <= y_pos[CNT_W-1:0];
         s1_ff.in_canvas    <= in_canvas;
         s1_ff.last         <= last;
      end
   end

   // --------------------------------------------------- blend and address
   logic [CHAN_W-1:0] blend_red, blend_green, blend_blue;
   logic [PROD_W-1:0] addr_full;

   crab_blend u_blend_red (
      .src    (s1_ff.src_red),
      .dst    (s1_ff.canvas_red),
      .alpha  (s1_ff.src_alpha),
      .result (blend_red)
   );

   crab_blend u_blend_green (
      .src    (s1_ff.src_green),
      .dst    (s1_ff.canvas_green),
      .alpha  (s1_ff.src_alpha),
      .result (blend_green)
   );

   crab_blend u_blend_blue (
      .src    (s1_ff.src_blue),
      .dst    (s1_ff.canvas_blue),
      .alpha  (s1_ff.src_alpha),
      .result (blend_blue)
   );

   // Read here; user keeps canvas width stable while pixels are in flight, not enforced.
   assign addr_full = PROD_W'(s1_ff.y) * PROD_W'(canvas_w) + PROD_W'(s1_ff.x);

   // ----------------------------------------------------------- result stage
   logic              we_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic              last_ff;

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         we_ff    <= s1_ff.in_canvas;
         last_ff  <= s1_ff.last;
         // Clipped pixels carry zero address and color.
         addr_ff  <= s1_ff.in_canvas ? ADDR_W'(addr_full) : '0;
         red_ff   <= s1_ff.in_canvas ? blend_red   : '0;
         green_ff <= s1_ff.in_canvas ? blend_green : '0;
         blue_ff  <= s1_ff.in_canvas ? blend_blue  : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_out_red       = red_ff;
   assign rsp_out_green     = green_ff;
   assign rsp_out_blue      = blue_ff;
   assign rsp_last_pixel    = last_ff;

   // ------------------------------------------------------------- assertions
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |->
         (rsp_pixel_address == '0 && rsp_out_red == '0
          && rsp_out_green == '0 && rsp_out_blue == '0))
      else $error("clipped pixel carries nonzero address or color");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (s1_load && last) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters did not return to origin after last pixel");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while both stages are stalled");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("input stage lost or changed a stalled transaction");

endmodule
